/* design/assert_macros.svh */
// Assertion macros for the checker file.
// No dependencies; include once per compile unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Hold: antecedent implies consequent in the same cycle.
`define FBDS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Hold: antecedent implies consequent in the next cycle.
`define FBDS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/fbds_pkg.sv */
// Package for the fractional baud divisor search: item types, widths, FSM states.
// No dependencies.
package fbds_pkg;

    localparam int CLK_W             = 32;
    localparam int BAUD_W            = 24;
    localparam int NIB_W             = 4;
    localparam int SUM_W             = 5;
    localparam int OUT_DIV_W         = 16;
    localparam int NUM_W             = CLK_W + NIB_W;          // clk * mul
    localparam int DD_W              = BAUD_W + SUM_W + 4;     // 16 * baud * (mul + add)
    localparam int N_W               = NUM_W + 2;              // 2 * num + dd
    localparam int DIVISOR_WIDTH_DEF = 16;

    localparam logic [NIB_W-1:0] NIB_MAX  = 4'd15;
    localparam logic [NIB_W-1:0] MUL_MIN  = 4'd1;
    localparam logic [NIB_W-1:0] ADD_MIN  = 4'd0;

    typedef struct packed {
        logic [CLK_W-1:0]  clock_hz;
        logic [BAUD_W-1:0] target_baud;
    } in_item_t;

    typedef struct packed {
        logic [OUT_DIV_W-1:0] divisor;
        logic [NIB_W-1:0]     add_value;
        logic [NIB_W-1:0]     mul_value;
        logic                 found;
    } out_item_t;

    // Classified job handed from the front to the search engine.
    typedef struct packed {
        logic [CLK_W-1:0]  clock_hz;
        logic [BAUD_W-1:0] target_baud;
        logic              zero_baud;
    } job_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_CHECK,
        S_DIV,
        S_ERR,
        S_MUL,
        S_CMP,
        S_DONE
    } search_state_t;

endpackage

/* design/fractional_baud_divisor_search.sv */
// Top level of the fractional baud divisor search: front queue, search engine,
// result register. Depends on fbds_pkg, fbds_front and fbds_search.
//
//   channel  | handshake        | payload
//   ---------+------------------+----------------------------------------------
//   input    | push / full      | item   : clock_hz, target_baud
//   result   | pop / empty      | result : divisor, add_value, mul_value, found
//
// Search: the engine walks all 240 add/mul pairs and runs each candidate through the
// bit-serial divider; a candidate whose divisor rounds to zero or overflows is skipped
// without a division. A zero baud rate skips the search and gives an all-zero result.
// Reset: asynchronous, empties the queue and the result register, clears the engine state.
// Stalls: the front queue takes two items while the engine runs; the result
// register lets the engine finish one more search while a result waits.
module fractional_baud_divisor_search
    import fbds_pkg::*;
#(
    parameter int DIVISOR_WIDTH = DIVISOR_WIDTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  in_item_t  item,
    output logic      empty,
    input  logic      pop,
    output out_item_t result
);

    logic      job_valid;
    job_t      job;
    logic      job_take;
    logic      res_valid;
    out_item_t res;
    logic      res_take;
    logic      out_valid_reg;
    out_item_t out_reg;

    // Accept and classify items, queue them for the engine.
    fbds_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .job_valid (job_valid),
        .job       (job),
        .job_take  (job_take)
    );

    // Run the search over all add/mul pairs.
    fbds_search #(
        .DW (DIVISOR_WIDTH)
    ) u_search (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job       (job),
        .job_take  (job_take),
        .res_valid (res_valid),
        .res       (res),
        .res_take  (res_take)
    );

    // Drop a finished item into the result register when it is free or being popped.
    assign res_take = res_valid && (!out_valid_reg || pop);
    assign empty    = !out_valid_reg;
    assign result   = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_take)
            out_valid_reg <= 1'b1;
        else if (pop)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
            out_reg <= res;
    end

endmodule

/* design/fbds_front.sv */
// Front end: accepts items, flags a zero baud rate, holds them in a two-entry queue.
// Depends on fbds_pkg.
module fbds_front
    import fbds_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    output logic     full,
    input  in_item_t item,
    output logic     job_valid,
    output job_t     job,
    input  logic     job_take
);

    job_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign full      = (count_reg == 2'd2);
    assign job_valid = (count_reg != 2'd0);
    assign job       = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = job_take && job_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg].clock_hz    <= item.clock_hz;
            entry_reg[wr_ptr_reg].target_baud <= item.target_baud;
            entry_reg[wr_ptr_reg].zero_baud   <= (item.target_baud == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

/* design/fbds_search.sv */
// Search engine: walks all add/mul pairs, divides bit by bit, keeps the best error.
// Depends on fbds_pkg.
module fbds_search
    import fbds_pkg::*;
#(
    parameter int DW = DIVISOR_WIDTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      job_valid,
    input  job_t      job,
    output logic      job_take,
    output logic      res_valid,
    output out_item_t res,
    input  logic      res_take
);

    localparam int CNT_W  = $clog2(DW);
    localparam int SH_W   = DD_W + DW;
    localparam int LIM_W  = DD_W + 1 + DW;
    localparam int ERRD_W = DW + 4 + SUM_W;
    localparam int QD_W   = DW + DD_W;
    localparam int PROD_W = DD_W + ERRD_W;
    localparam int EXT_W  = (DW > OUT_DIV_W) ? DW : OUT_DIV_W;

    search_state_t state_reg, state_next;

    logic [CLK_W-1:0]  clk_reg;
    logic [BAUD_W-1:0] baud_reg;
    logic [NIB_W-1:0]  add_reg;
    logic [NIB_W-1:0]  mul_reg;
    logic [DD_W-1:0]   dd_reg;
    logic [NUM_W-1:0]  num_reg;
    logic [N_W-1:0]    rem_reg;
    logic [SH_W-1:0]   sh_reg;
    logic [DW-1:0]     q_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DD_W-1:0]   errn_reg;
    logic [ERRD_W-1:0] errd_reg;
    logic [PROD_W-1:0] p1_reg;
    logic [PROD_W-1:0] p2_reg;
    logic              have_reg;
    logic [DD_W-1:0]   best_n_reg;
    logic [ERRD_W-1:0] best_d_reg;
    logic [DW-1:0]     best_div_reg;
    logic [NIB_W-1:0]  best_add_reg;
    logic [NIB_W-1:0]  best_mul_reg;

    logic [SUM_W-1:0]  sum;
    logic [N_W-1:0]    n_val;
    logic [LIM_W-1:0]  two_dd;
    logic              too_small;
    logic              too_large;
    logic              skip;
    logic [SH_W-1:0]   rem_ext;
    logic              ge;
    logic [SH_W-1:0]   rem_sub;
    logic [QD_W-1:0]   prod;
    logic [QD_W-1:0]   num_ext;
    logic [QD_W-1:0]   diff;
    logic              better;
    logic              last_pair;
    logic [EXT_W-1:0]  div_ext;

    assign sum       = {1'b0, mul_reg} + {1'b0, add_reg};
    assign n_val     = {num_reg, 1'b0} + N_W'(dd_reg);
    assign two_dd    = LIM_W'({dd_reg, 1'b0});
    assign too_small = LIM_W'(n_val) < two_dd;
    assign too_large = LIM_W'(n_val) >= (two_dd << DW);
    assign skip      = too_small || too_large;
    assign rem_ext   = SH_W'(rem_reg);
    assign ge        = rem_ext >= sh_reg;
    assign rem_sub   = rem_ext - sh_reg;
    assign prod      = QD_W'(q_reg) * QD_W'(dd_reg);
    assign num_ext   = QD_W'(num_reg);
    assign diff      = (num_ext >= prod) ? (num_ext - prod) : (prod - num_ext);
    assign better    = !have_reg || (p1_reg < p2_reg);
    assign last_pair = (add_reg == NIB_MAX) && (mul_reg == NIB_MAX);
    assign div_ext   = EXT_W'(best_div_reg);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (job_valid)
                    state_next = job.zero_baud ? S_DONE : S_SETUP;
            S_SETUP:
                state_next = S_CHECK;
            S_CHECK:
                if (!skip)
                    state_next = S_DIV;
                else if (last_pair)
                    state_next = S_DONE;
                else
                    state_next = S_SETUP;
            S_DIV:
                if (cnt_reg == '0)
                    state_next = S_ERR;
            S_ERR:
                state_next = S_MUL;
            S_MUL:
                state_next = S_CMP;
            S_CMP:
                state_next = last_pair ? S_DONE : S_SETUP;
            S_DONE:
                if (res_take)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // Outputs.
    always_comb
    begin
        job_take      = (state_reg == S_IDLE) && job_valid;
        res_valid     = (state_reg == S_DONE);
        res.divisor   = div_ext[OUT_DIV_W-1:0];
        res.add_value = best_add_reg;
        res.mul_value = best_mul_reg;
        res.found     = have_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            have_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (job_take)
                have_reg <= 1'b0;
            else if (state_reg == S_CMP && better)
                have_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                clk_reg      <= job.clock_hz;
                baud_reg     <= job.target_baud;
                add_reg      <= ADD_MIN;
                mul_reg      <= MUL_MIN;
                best_n_reg   <= '0;
                best_d_reg   <= '0;
                best_div_reg <= '0;
                best_add_reg <= '0;
                best_mul_reg <= '0;
            end
            S_SETUP:
            begin
                dd_reg  <= DD_W'({DD_W'(baud_reg) * DD_W'(sum), 4'b0});
                num_reg <= NUM_W'(clk_reg) * NUM_W'(mul_reg);
            end
            S_CHECK:
            begin
                rem_reg <= n_val;
                sh_reg  <= SH_W'({dd_reg, 1'b0}) << (DW - 1);
                cnt_reg <= CNT_W'(DW - 1);
                if (skip)
                begin
                    // Advance to the next pair; mul runs inside add.
                    if (mul_reg == NIB_MAX)
                    begin
                        mul_reg <= MUL_MIN;
                        add_reg <= add_reg + 4'd1;
                    end
                    else
                        mul_reg <= mul_reg + 4'd1;
                end
            end
            S_DIV:
            begin
                if (ge)
                    rem_reg <= rem_sub[N_W-1:0];
                q_reg   <= {q_reg[DW-2:0], ge};
                sh_reg  <= sh_reg >> 1;
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
            S_ERR:
            begin
                errn_reg <= diff[DD_W-1:0];
                errd_reg <= ERRD_W'({q_reg, 4'b0}) * ERRD_W'(sum);
            end
            S_MUL:
            begin
                p1_reg <= PROD_W'(errn_reg) * PROD_W'(best_d_reg);
                p2_reg <= PROD_W'(best_n_reg) * PROD_W'(errd_reg);
            end
            S_CMP:
            begin
                if (better)
                begin
                    best_n_reg   <= errn_reg;
                    best_d_reg   <= errd_reg;
                    best_div_reg <= q_reg;
                    best_add_reg <= add_reg;
                    best_mul_reg <= mul_reg;
                end
                if (mul_reg == NIB_MAX)
                begin
                    mul_reg <= MUL_MIN;
                    add_reg <= add_reg + 4'd1;
                end
                else
                    mul_reg <= mul_reg + 4'd1;
            end
            default:
            begin
            end
        endcase
    end

endmodule

/* design/fbds_checker.sv */
// Port-level checker for the fractional baud divisor search, bound to the top level.
// Depends on fbds_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fbds_checker
    import fbds_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      push,
    input logic      full,
    input logic      empty,
    input logic      pop,
    input out_item_t result
);

    logic result_zero;
    logic result_set;

    assign result_zero = (result.divisor == '0) && (result.add_value == '0)
                         && (result.mul_value == '0);
    assign result_set  = (result.divisor != '0) && (result.mul_value != '0);

    `FBDS_ASSERT_NOW(a_none_is_zero, !empty && !result.found, result_zero, "no-candidate not zero")
    `FBDS_ASSERT_NOW(a_found_valid, !empty && result.found, result_set, "found result is zero")
    `FBDS_ASSERT_NEXT(a_result_holds, !empty && !pop, !empty && $stable(result), "result changed")
    `FBDS_ASSERT_NOW(a_full_needs_push, $rose(full), $past(push), "queue filled without a push")

endmodule

bind fractional_baud_divisor_search fbds_checker u_fbds_checker (.*);
